// ===== rtl/jsbv_pkg.sv =====
// Package for the JSON string body validator: request and response structs,
// status, function and phase codes, character constants and the hex decoder.
// Depends on nothing; every RTL file of the block imports it.
package jsbv_pkg;

  localparam int unsigned LengthBits = 24;
  localparam int unsigned CountBits  = LengthBits + 1;

  localparam logic [LengthBits-1:0] MaxBodyReset = LengthBits'(1048576);

  typedef logic [1:0] func_t;
  localparam func_t FUNC_BEGIN = 2'd0;
  localparam func_t FUNC_DATA  = 2'd1;
  localparam func_t FUNC_END   = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t ST_PENDING  = 3'd0;
  localparam status_t ST_COMPLETE = 3'd1;
  localparam status_t ST_SYNTAX   = 3'd2;
  localparam status_t ST_EOF      = 3'd3;
  localparam status_t ST_UNICODE  = 3'd4;
  localparam status_t ST_UTF8     = 3'd5;
  localparam status_t ST_LARGE    = 3'd6;
  localparam status_t ST_INACTIVE = 3'd7;

  typedef enum logic [6:0] {
    PH_NORMAL   = 7'b0000001,
    PH_ESCAPE   = 7'b0000010,
    PH_HEX_HI   = 7'b0000100,
    PH_WANT_BS  = 7'b0001000,
    PH_WANT_U   = 7'b0010000,
    PH_HEX_LO   = 7'b0100000,
    PH_UTF8     = 7'b1000000
  } phase_t;

  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_CTRL_END = 8'h20;
  localparam logic [7:0] UTF8_CONT_MASK = 8'hC0;
  localparam logic [7:0] UTF8_CONT_TAG  = 8'h80;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC2;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF8_LEAD_END = 8'hF5;

  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;

  typedef struct packed {
    func_t      func;
    logic [7:0] data_byte;
    logic       single_quoted;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic                 has_escape;
    logic [CountBits-1:0] body_length;
  } rsp_t;

  // Returns {valid, nibble} for an ASCII hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, b[3:0]};
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== rtl/json_string_body_validator_core.sv =====
// Top level of the JSON string body validator: string state, per-byte checks
// and a registered response stage with a configurable body length limit.
// Depends on jsbv_pkg.
//
//   Port group | Direction | Payload
//   in_        | request   | jsbv_pkg::req_t (func, data_byte, single_quoted)
//   out_       | response  | jsbv_pkg::rsp_t (status, has_escape, body_length)
//   cfg_       | write     | max_body_bytes, 24 bits
//
// One request is taken per cycle unless a stalled response holds the output
// register; its response is registered there on acceptance. The rate is set
// by the single state update per byte. A new request is taken in the same
// cycle the held response leaves. Reset closes any string, empties the output
// register and sets the limit to 1048576.
module json_string_body_validator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  jsbv_pkg::req_t                in_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output jsbv_pkg::rsp_t                out_rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [jsbv_pkg::LengthBits-1:0] cfg_data
);
  import jsbv_pkg::*;

  logic [LengthBits-1:0] max_r;
  logic                  active_r, active_nxt;
  logic                  single_r, single_nxt;
  phase_t                phase_r, phase_nxt;
  logic [15:0]           hex_r, hex_nxt;
  logic [2:0]            left_r, left_nxt;
  logic                  esc_r, esc_nxt;
  logic [CountBits-1:0]  count_r, count_nxt;
  logic                  out_valid_r;
  rsp_t                  out_rsp_r;
  status_t               status;
  logic                  in_fire;
  logic [7:0]            c;
  logic [7:0]            closer;
  logic [4:0]            hd;
  logic [15:0]           hex_shift;
  logic [2:0]            left_dec;
  logic                  under_limit;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign c           = in_req.data_byte;
  assign closer      = single_r ? CH_SQUOTE : CH_DQUOTE;
  assign hd          = hex_digit(c);
  assign hex_shift   = {hex_r[11:0], hd[3:0]};
  assign left_dec    = (left_r != 3'd0) ? left_r - 3'd1 : 3'd0;
  assign under_limit = count_r <= {1'b0, max_r};

  always_comb begin
    active_nxt = active_r;
    single_nxt = single_r;
    phase_nxt  = phase_r;
    hex_nxt    = hex_r;
    left_nxt   = left_r;
    esc_nxt    = esc_r;
    count_nxt  = count_r;
    status     = ST_PENDING;
    if (in_req.func == FUNC_BEGIN) begin
      active_nxt = 1'b1;
      single_nxt = in_req.single_quoted;
      phase_nxt  = PH_NORMAL;
      hex_nxt    = 16'd0;
      left_nxt   = 3'd0;
      esc_nxt    = 1'b0;
      count_nxt  = '0;
    end else if (!active_r) begin
      status = ST_INACTIVE;
    end else if (in_req.func == FUNC_DATA) begin
      if (phase_r == PH_NORMAL && c == closer) begin
        active_nxt = 1'b0;
        status     = under_limit ? ST_COMPLETE : ST_LARGE;
      end else begin
        if (under_limit) begin
          count_nxt = count_r + 1'b1;
        end
        case (phase_r)
          PH_NORMAL: begin
            if (c < CH_CTRL_END) begin
              active_nxt = 1'b0;
              status     = ST_SYNTAX;
            end else if (c == CH_BSLASH) begin
              esc_nxt   = 1'b1;
              phase_nxt = PH_ESCAPE;
            end else if (c < UTF8_CONT_TAG) begin
              status = ST_PENDING;
            end else if (c < UTF8_LEAD2 || c >= UTF8_LEAD_END) begin
              active_nxt = 1'b0;
              status     = ST_UTF8;
            end else begin
              phase_nxt = PH_UTF8;
              if (c < UTF8_LEAD3) begin
                left_nxt = 3'd1;
              end else if (c < UTF8_LEAD4) begin
                left_nxt = 3'd2;
              end else begin
                left_nxt = 3'd3;
              end
            end
          end
          PH_ESCAPE: begin
            if (c == CH_LOWER_U) begin
              phase_nxt = PH_HEX_HI;
              left_nxt  = 3'd4;
              hex_nxt   = 16'd0;
            end else if (c inside {CH_DQUOTE, CH_BSLASH, CH_SLASH, 8'h62, 8'h66,
                                   8'h6E, 8'h72, 8'h74} ||
                         (c == CH_SQUOTE && single_r)) begin
              phase_nxt = PH_NORMAL;
            end else begin
              active_nxt = 1'b0;
              status     = ST_SYNTAX;
            end
          end
          PH_HEX_HI, PH_HEX_LO: begin
            if (!hd[4]) begin
              active_nxt = 1'b0;
              status     = ST_UNICODE;
            end else begin
              hex_nxt  = hex_shift;
              left_nxt = left_dec;
              if (left_dec == 3'd0) begin
                if (phase_r == PH_HEX_LO) begin
                  if (hex_shift < LO_SURR_MIN || hex_shift > LO_SURR_MAX) begin
                    active_nxt = 1'b0;
                    status     = ST_UNICODE;
                  end else begin
                    phase_nxt = PH_NORMAL;
                  end
                end else if (hex_shift >= HI_SURR_MIN && hex_shift <= HI_SURR_MAX) begin
                  phase_nxt = PH_WANT_BS;
                end else if (hex_shift >= LO_SURR_MIN && hex_shift <= LO_SURR_MAX) begin
                  active_nxt = 1'b0;
                  status     = ST_UNICODE;
                end else begin
                  phase_nxt = PH_NORMAL;
                end
              end
            end
          end
          PH_WANT_BS: begin
            if (c == CH_BSLASH) begin
              phase_nxt = PH_WANT_U;
            end else begin
              active_nxt = 1'b0;
              status     = ST_UNICODE;
            end
          end
          PH_WANT_U: begin
            if (c == CH_LOWER_U) begin
              phase_nxt = PH_HEX_LO;
              left_nxt  = 3'd4;
              hex_nxt   = 16'd0;
            end else begin
              active_nxt = 1'b0;
              status     = ST_UNICODE;
            end
          end
          default: begin
            if ((c & UTF8_CONT_MASK) != UTF8_CONT_TAG) begin
              active_nxt = 1'b0;
              status     = ST_UTF8;
            end else begin
              left_nxt = left_dec;
              if (left_dec == 3'd0) begin
                phase_nxt = PH_NORMAL;
              end
            end
          end
        endcase
      end
    end else if (in_req.func == FUNC_END) begin
      active_nxt = 1'b0;
      case (phase_r)
        PH_NORMAL, PH_ESCAPE: status = ST_EOF;
        PH_UTF8:              status = ST_UTF8;
        default:              status = ST_UNICODE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= MaxBodyReset;
      active_r    <= 1'b0;
      single_r    <= 1'b0;
      phase_r     <= PH_NORMAL;
      hex_r       <= 16'd0;
      left_r      <= 3'd0;
      esc_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_data;
      end
      if (in_fire) begin
        active_r    <= active_nxt;
        single_r    <= single_nxt;
        phase_r     <= phase_nxt;
        hex_r       <= hex_nxt;
        left_r      <= left_nxt;
        esc_r       <= esc_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_rsp_r.status      <= status;
      out_rsp_r.has_escape  <= esc_nxt;
      out_rsp_r.body_length <= count_nxt;
    end
  end

  a_begin_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_req.func == FUNC_BEGIN |=>
      out_valid && out_rsp.status == ST_PENDING && out_rsp.body_length == '0 &&
      !out_rsp.has_escape)
    else $error("Begin request did not give an empty pending response.");

  a_inactive_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !active_r && in_req.func != FUNC_BEGIN |=>
      out_rsp.status == ST_INACTIVE && $stable(count_r))
    else $error("Request with no open string changed state or status.");

  a_utf8_left: assert property (@(posedge clk) disable iff (!rst_n)
    active_r && phase_r == PH_UTF8 |-> left_r != 3'd0 && left_r < 3'd4)
    else $error("Open UTF-8 sequence has no continuation bytes pending.");

  a_hold_resp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("Stalled response was lost or changed.");

endmodule

// ===== dv/json_string_body_validator_core_test.sv =====
// Self-checking testbench for json_string_body_validator_core: directed and random
// string bodies go in with random gaps and output stalls, and every response is
// compared with a behavioral predictor. Depends on jsbv_pkg and the core RTL.
module json_string_body_validator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jsbv_pkg::*;

  localparam func_t      FUNC_UNUSED     = 2'd3;
  localparam int         QUIET_LIMIT     = 2000;
  localparam int         RANDOM_REQUESTS = 850;
  localparam int         PHASE_REQUESTS  = 170;
  localparam logic [7:0] ASCII_0         = 8'h30;
  localparam logic [7:0] ASCII_9         = 8'h39;
  localparam logic [7:0] UPPER_A         = 8'h41;
  localparam logic [7:0] UPPER_D         = 8'h44;
  localparam logic [7:0] UPPER_F         = 8'h46;
  localparam logic [7:0] LOWER_A         = 8'h61;
  localparam logic [7:0] LOWER_F         = 8'h66;
  localparam logic [7:0] ASCII_DEL       = 8'h7F;
  localparam logic [7:0] ESC_B           = 8'h62;
  localparam logic [7:0] ESC_N           = 8'h6E;
  localparam logic [7:0] ESC_R           = 8'h72;
  localparam logic [7:0] ESC_T           = 8'h74;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  req_t                  in_req    = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  rsp_t                  out_rsp;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [LengthBits-1:0] cfg_data  = '0;

  // Predictor state, updated as each request is accepted.
  logic [LengthBits-1:0] limit_model = MaxBodyReset;
  logic                  str_open    = 1'b0;
  logic                  str_single  = 1'b0;
  phase_t                cur_phase   = PH_NORMAL;
  logic [15:0]           hex_acc     = '0;
  logic [2:0]            cont_left   = '0;
  logic                  esc_seen    = 1'b0;
  logic [CountBits-1:0]  body_count  = '0;

  rsp_t       expected_rsp_q[$];
  bit         mismatch_seen = 1'b0;
  bit         no_idle       = 1'b0;
  int         requests_sent = 0;
  logic [7:0] escape_letters [9] = '{CH_DQUOTE, CH_BSLASH, CH_SLASH, ESC_B, LOWER_F,
                                     ESC_N, ESC_R, ESC_T, CH_SQUOTE};

  json_string_body_validator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic rsp_t predict_validator(input req_t r);
    rsp_t       res;
    status_t    st;
    logic [7:0] c;
    logic [3:0] nib;
    logic       is_hex;
    c = r.data_byte;
    st = ST_PENDING;
    nib = 4'd0;
    is_hex = 1'b1;
    if (c >= ASCII_0 && c <= ASCII_9) begin
      nib = c[3:0];
    end else if ((c >= UPPER_A && c <= UPPER_F) || (c >= LOWER_A && c <= LOWER_F)) begin
      nib = c[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
    if (r.func == FUNC_BEGIN) begin
      str_open = 1'b1;
      str_single = r.single_quoted;
      cur_phase = PH_NORMAL;
      hex_acc = '0;
      cont_left = '0;
      esc_seen = 1'b0;
      body_count = '0;
    end else if (!str_open) begin
      st = ST_INACTIVE;
    end else if (r.func == FUNC_END) begin
      case (cur_phase)
        PH_NORMAL, PH_ESCAPE: st = ST_EOF;
        PH_UTF8: st = ST_UTF8;
        default: st = ST_UNICODE;
      endcase
      str_open = 1'b0;
    end else if (r.func == FUNC_DATA) begin
      if (cur_phase == PH_NORMAL && c == (str_single ? CH_SQUOTE : CH_DQUOTE)) begin
        str_open = 1'b0;
        st = (body_count > limit_model) ? ST_LARGE : ST_COMPLETE;
      end else begin
        if (body_count <= limit_model) body_count = body_count + 1'b1;
        case (cur_phase)
          PH_NORMAL: begin
            if (c < CH_CTRL_END) begin
              st = ST_SYNTAX;
            end else if (c == CH_BSLASH) begin
              esc_seen = 1'b1;
              cur_phase = PH_ESCAPE;
            end else if (c >= UTF8_CONT_TAG) begin
              if (c < UTF8_LEAD2 || c >= UTF8_LEAD_END) begin
                st = ST_UTF8;
              end else begin
                cont_left = (c < UTF8_LEAD3) ? 3'd1 : (c < UTF8_LEAD4) ? 3'd2 : 3'd3;
                cur_phase = PH_UTF8;
              end
            end
          end
          PH_ESCAPE: begin
            if (c == CH_LOWER_U) begin
              cur_phase = PH_HEX_HI;
              cont_left = 3'd4;
              hex_acc = '0;
            end else if (c inside {CH_DQUOTE, CH_BSLASH, CH_SLASH, ESC_B, LOWER_F, ESC_N,
                                   ESC_R, ESC_T} || (str_single && c == CH_SQUOTE)) begin
              cur_phase = PH_NORMAL;
            end else begin
              st = ST_SYNTAX;
            end
          end
          PH_HEX_HI, PH_HEX_LO: begin
            if (!is_hex) begin
              st = ST_UNICODE;
            end else begin
              hex_acc = {hex_acc[11:0], nib};
              if (cont_left != 0) cont_left = cont_left - 1'b1;
              if (cont_left == 0) begin
                if (cur_phase == PH_HEX_LO) begin
                  if (hex_acc < LO_SURR_MIN || hex_acc > LO_SURR_MAX) st = ST_UNICODE;
                  else cur_phase = PH_NORMAL;
                end else if (hex_acc >= HI_SURR_MIN && hex_acc <= HI_SURR_MAX) begin
                  cur_phase = PH_WANT_BS;
                end else if (hex_acc >= LO_SURR_MIN && hex_acc <= LO_SURR_MAX) begin
                  st = ST_UNICODE;
                end else begin
                  cur_phase = PH_NORMAL;
                end
              end
            end
          end
          PH_WANT_BS: begin
            if (c == CH_BSLASH) cur_phase = PH_WANT_U;
            else st = ST_UNICODE;
          end
          PH_WANT_U: begin
            if (c == CH_LOWER_U) begin
              cur_phase = PH_HEX_LO;
              cont_left = 3'd4;
              hex_acc = '0;
            end else begin
              st = ST_UNICODE;
            end
          end
          default: begin
            if ((c & UTF8_CONT_MASK) != UTF8_CONT_TAG) begin
              st = ST_UTF8;
            end else begin
              if (cont_left != 0) cont_left = cont_left - 1'b1;
              if (cont_left == 0) cur_phase = PH_NORMAL;
            end
          end
        endcase
        if (st != ST_PENDING) str_open = 1'b0;
      end
    end
    res.status = st;
    res.has_escape = esc_seen;
    res.body_length = body_count;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_seen = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) limit_model = cfg_data;
      if (in_valid && in_ready) expected_rsp_q.push_back(predict_validator(in_req));
      if (out_valid && out_ready) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t ns: response with no request outstanding, expected none actual %p",
                   $time, out_rsp);
          mismatch_seen = 1'b1;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_rsp.status));
          check_field("has_escape", 32'(want.has_escape), 32'(out_rsp.has_escape));
          check_field("body_length", 32'(want.body_length), 32'(out_rsp.body_length));
        end
      end
    end
  end

  initial begin : response_sink
    int hold;
    forever begin
      @(posedge clk);
      hold = no_idle ? 0 : pick_gap();
      out_ready <= (hold == 0);
      if (hold > 1) repeat (hold - 1) @(posedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("json_string_body_validator_core: mismatch");
    $finish;
  end

  // The single_quoted bit only matters on a begin request, so it is random elsewhere.
  task automatic send_request(input func_t f, input logic [7:0] b, input logic q);
    req_t r;
    int   gap;
    r.func = f;
    r.data_byte = b;
    r.single_quoted = (f == FUNC_BEGIN) ? q : 1'($urandom);
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic drain_responses();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LengthBits-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_unicode_escape(input logic [15:0] value, input int digits);
    logic [3:0] nib;
    logic [7:0] ch;
    send_request(FUNC_DATA, CH_BSLASH, 1'b0);
    send_request(FUNC_DATA, CH_LOWER_U, 1'b0);
    for (int i = 0; i < digits; i++) begin
      nib = value[15 - 4*i -: 4];
      if (nib < 4'd10) ch = ASCII_0 + nib;
      else ch = ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + nib - 8'd10;
      send_request(FUNC_DATA, ch, 1'b0);
    end
  endtask

  task automatic send_random_string();
    logic        sq;
    logic [7:0]  closer;
    logic [7:0]  ch;
    logic [15:0] cp;
    int          roll;
    int          n_cont;
    sq = 1'($urandom);
    closer = sq ? CH_SQUOTE : CH_DQUOTE;
    no_idle = ($urandom_range(0, 4) == 0);
    send_request(FUNC_BEGIN, 8'($urandom), sq);
    repeat ($urandom_range(0, 12)) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        ch = 8'($urandom_range(CH_CTRL_END, ASCII_DEL));
        if (ch == closer || ch == CH_BSLASH) ch = UPPER_A;
        send_request(FUNC_DATA, ch, 1'b0);
      end else if (roll < 52) begin
        send_request(FUNC_DATA, CH_BSLASH, 1'b0);
        send_request(FUNC_DATA, escape_letters[$urandom_range(0, sq ? 8 : 7)], 1'b0);
      end else if (roll < 60) begin
        cp = 16'($urandom);
        if ($urandom_range(0, 9) != 0 && cp >= HI_SURR_MIN && cp <= LO_SURR_MAX) cp[15] = 1'b0;
        send_unicode_escape(cp, 4);
      end else if (roll < 66) begin
        send_unicode_escape(HI_SURR_MIN | 16'($urandom_range(0, 1023)), 4);
        send_unicode_escape(LO_SURR_MIN | 16'($urandom_range(0, 1023)), 4);
      end else if (roll < 84) begin
        n_cont = $urandom_range(1, 3);
        case (n_cont)
          1: ch = 8'($urandom_range(UTF8_LEAD2, UTF8_LEAD3 - 8'd1));
          2: ch = 8'($urandom_range(UTF8_LEAD3, UTF8_LEAD4 - 8'd1));
          default: ch = 8'($urandom_range(UTF8_LEAD4, UTF8_LEAD_END - 8'd1));
        endcase
        send_request(FUNC_DATA, ch, 1'b0);
        repeat (n_cont) send_request(FUNC_DATA, {2'b10, 6'($urandom)}, 1'b0);
      end else if (roll < 89) begin
        send_request(FUNC_DATA, sq ? CH_DQUOTE : CH_SQUOTE, 1'b0);
      end else if (roll < 92) begin
        send_request(FUNC_UNUSED, 8'($urandom), 1'b0);
      end else if (roll < 96) begin
        // Cut a sequence short so the next byte or the end lands mid-escape or mid-UTF-8.
        case ($urandom_range(0, 2))
          0: send_unicode_escape(16'($urandom), $urandom_range(0, 3));
          1: send_unicode_escape(HI_SURR_MIN | 16'($urandom_range(0, 1023)), 4);
          default: send_request(FUNC_DATA, 8'($urandom_range(UTF8_LEAD2, UTF8_LEAD_END - 8'd1)),
                                1'b0);
        endcase
      end else begin
        send_request(FUNC_DATA, 8'($urandom), 1'b0);
      end
    end
    roll = $urandom_range(0, 99);
    if (roll < 80) send_request(FUNC_DATA, closer, 1'b0);
    else if (roll < 92) send_request(FUNC_END, 8'($urandom), 1'b0);
  endtask

  task automatic test_idle_requests();
    send_request(FUNC_DATA, 8'hFF, 1'b1);
    send_request(FUNC_END, 8'h00, 1'b0);
    send_request(FUNC_UNUSED, 8'hA5, 1'b0);
    send_request(FUNC_BEGIN, 8'h00, 1'b0);
    send_request(FUNC_UNUSED, 8'h5A, 1'b1);
    send_request(FUNC_BEGIN, 8'hFF, 1'b1);
    send_request(FUNC_DATA, CH_SQUOTE, 1'b0);
    drain_responses();
  endtask

  task automatic test_escape_rules();
    send_request(FUNC_BEGIN, 8'h00, 1'b1);
    send_request(FUNC_DATA, CH_BSLASH, 1'b0);
    send_request(FUNC_DATA, CH_SQUOTE, 1'b0);
    send_request(FUNC_DATA, CH_DQUOTE, 1'b0);
    send_request(FUNC_DATA, CH_BSLASH, 1'b0);
    send_request(FUNC_DATA, CH_LOWER_U, 1'b0);
    send_request(FUNC_DATA, UPPER_D, 1'b0);
    send_request(FUNC_DATA, CH_SQUOTE, 1'b0);
    send_request(FUNC_BEGIN, 8'h00, 1'b0);
    send_request(FUNC_DATA, CH_BSLASH, 1'b0);
    send_request(FUNC_DATA, CH_SQUOTE, 1'b0);
    drain_responses();
  endtask

  task automatic test_utf8_and_controls();
    send_request(FUNC_BEGIN, 8'h00, 1'b0);
    send_request(FUNC_DATA, 8'hF4, 1'b0);
    send_request(FUNC_DATA, UTF8_CONT_TAG, 1'b0);
    send_request(FUNC_DATA, CH_DQUOTE, 1'b0);
    send_request(FUNC_BEGIN, 8'h00, 1'b0);
    send_request(FUNC_DATA, CH_CTRL_END - 8'd1, 1'b0);
    send_request(FUNC_BEGIN, 8'h00, 1'b1);
    send_request(FUNC_DATA, CH_BSLASH, 1'b0);
    send_request(FUNC_END, 8'hFF, 1'b0);
    drain_responses();
  endtask

  task automatic test_length_limit();
    write_limit('0);
    send_request(FUNC_BEGIN, 8'h00, 1'b0);
    send_request(FUNC_DATA, ASCII_DEL, 1'b0);
    send_request(FUNC_DATA, CH_CTRL_END, 1'b0);
    send_request(FUNC_DATA, CH_DQUOTE, 1'b0);
    drain_responses();
    write_limit('1);
    send_request(FUNC_BEGIN, 8'h00, 1'b1);
    send_request(FUNC_DATA, CH_DQUOTE, 1'b0);
    send_request(FUNC_DATA, CH_SQUOTE, 1'b0);
    drain_responses();
  endtask

  task automatic test_random_strings();
    int stop_at;
    int phase_end;
    stop_at = requests_sent + RANDOM_REQUESTS;
    for (int p = 0; requests_sent < stop_at; p++) begin
      drain_responses();
      case (p % 5)
        0: write_limit(LengthBits'($urandom_range(0, 24)));
        1: write_limit('1);
        2: write_limit(LengthBits'($urandom_range(1, 6)));
        3: write_limit(MaxBodyReset);
        default: write_limit(LengthBits'($urandom));
      endcase
      phase_end = requests_sent + PHASE_REQUESTS;
      while (requests_sent < phase_end) send_random_string();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_requests();
    test_escape_rules();
    test_utf8_and_controls();
    test_length_limit();
    test_random_strings();
    drain_responses();
    repeat (4) @(posedge clk);
    if (!mismatch_seen && expected_rsp_q.size() == 0) begin
      $display("json_string_body_validator_core: match");
    end else begin
      $display("json_string_body_validator_core: mismatch");
    end
    $finish;
  end

endmodule
